>>> sv/skep_pkg.sv
// Shared constants, command/status types and step codes for the k-mer edge packer.
// No dependencies; imported by every module of the block.
package skep_pkg;

  localparam int MAX_EDGE_BASES = 64;
  localparam int MULTI_BITS     = 16;
  localparam int MAX_WORDS      = 5;
  localparam int WORD_W         = 32;
  localparam int BASES_PER_WORD = WORD_W / 2;

  localparam int KMER_W  = 8;
  localparam int STEP_W  = 5;
  localparam int LEN_W   = 32;
  localparam int PRIOR_W = 24;
  localparam int E_W     = 9;

  localparam logic [KMER_W-1:0] KMER_RESET = 8'd21;
  localparam logic [STEP_W-1:0] STEP_RESET = 5'd10;

  localparam int   APB_ADDR_W = 3;
  localparam logic REG_KMER   = 1'b0;
  localparam logic REG_STEP   = 1'b1;

  localparam int WIN_W     = 2 * MAX_EDGE_BASES;
  localparam int PAD_BASES = (MAX_EDGE_BASES > BASES_PER_WORD * MAX_WORDS) ?
                             MAX_EDGE_BASES : BASES_PER_WORD * MAX_WORDS;
  localparam int NW_W      = $clog2(MAX_WORDS + 1);

  // multiplicity conversion widths
  localparam int EB_W      = $clog2(MAX_EDGE_BASES + 1);
  localparam int D_W       = 6;
  localparam int DE_W      = D_W + EB_W;
  localparam int DEN_W     = DE_W + LEN_W;
  localparam int DEN2_W    = DEN_W + 9;
  localparam int S1_W      = 2 * D_W;
  localparam int S_W       = LEN_W + D_W;
  localparam int S_HI_W    = S_W - 32;
  localparam int PK_W      = PRIOR_W + KMER_W;
  localparam int PHI_W     = PK_W + S_HI_W;
  localparam int N_W       = PK_W + S_W;
  localparam int DVD_W     = N_W + 2;
  localparam int DIV_STEPS = DVD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam int CONV_STEPS = 8;
  localparam int CS_W       = $clog2(CONV_STEPS);

  localparam logic [CS_W-1:0] CS_LEN   = 3'd0;
  localparam logic [CS_W-1:0] CS_RANGE = 3'd1;
  localparam logic [CS_W-1:0] CS_SPAN  = 3'd2;
  localparam logic [CS_W-1:0] CS_PART  = 3'd3;
  localparam logic [CS_W-1:0] CS_SUM   = 3'd4;
  localparam logic [CS_W-1:0] CS_MUL   = 3'd5;
  localparam logic [CS_W-1:0] CS_ACC   = 3'd6;
  localparam logic [CS_W-1:0] CS_DVD   = 3'd7;

  typedef struct packed {
    logic            take;
    logic            conv;
    logic [CS_W-1:0] conv_step;
    logic            div_step;
    logic            fin;
    logic            load;
    logic [NW_W-1:0] word_idx;
    logic            word_last;
  } skep_cmd_t;

  typedef struct packed {
    logic            start_conv;
    logic            do_emit;
    logic [NW_W-1:0] nw;
    logic            out_free;
  } skep_stat_t;

endpackage

>>> sv/skep_regs.sv
// APB register file: k-mer size and step size.
// Depends on skep_pkg.
module skep_regs import skep_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [KMER_W-1:0]     kmer_size_o,
  output logic [STEP_W-1:0]     step_size_o
);

  logic              wr;
  logic              idx;
  logic [KMER_W-1:0] kmer_q;
  logic [STEP_W-1:0] step_q;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[APB_ADDR_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_q <= KMER_RESET;
      step_q <= STEP_RESET;
    end else if (wr) begin
      if (idx == REG_KMER) begin
        kmer_q <= pwdata[KMER_W-1:0];
      end else begin
        step_q <= pwdata[STEP_W-1:0];
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_KMER: prdata = {{(32-KMER_W){1'b0}}, kmer_q};
      REG_STEP: prdata = {{(32-STEP_W){1'b0}}, step_q};
      default:  prdata = '0;
    endcase
  end

  assign kmer_size_o = kmer_q;
  assign step_size_o = step_q;

endmodule

>>> sv/skep_ctrl.sv
// Controller: sequences intake, multiplicity conversion, division and word output.
// Depends on skep_pkg.
module skep_ctrl import skep_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  skep_stat_t stat_i,
  output skep_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NW_W-1:0]  nw_q, nw_d;
  logic             emit_q, emit_d;
  logic             take;
  logic             word_last;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    nw_d      = nw_q;
    emit_d    = emit_q;
    s_ready_o = (state_q == ST_IDLE);
    take      = s_valid_i && s_ready_o;
    word_last = (cnt_q[NW_W-1:0] == nw_q - NW_W'(1));

    cmd_o           = '0;
    cmd_o.take      = take;
    cmd_o.conv_step = cnt_q[CS_W-1:0];
    cmd_o.word_idx  = cnt_q[NW_W-1:0];
    cmd_o.word_last = word_last;

    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          cnt_d  = '0;
          nw_d   = stat_i.nw;
          emit_d = stat_i.do_emit;
          if (stat_i.start_conv) begin
            state_d = ST_CONV;
          end else if (stat_i.do_emit) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_CONV: begin
        cmd_o.conv = 1'b1;
        if (cnt_q[CS_W-1:0] == CS_DVD) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_FIN;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        cnt_d     = '0;
        state_d   = emit_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          if (word_last) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      nw_q    <= '0;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      nw_q    <= nw_d;
      emit_q  <= emit_d;
    end
  end

endmodule

>>> sv/skep_dp.sv
// Datapath: base window, contig state, multiplicity conversion with a
// bit-serial divider, edge word assembly and output register. Depends on skep_pkg.
module skep_dp import skep_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  skep_cmd_t          cmd_i,
  output skep_stat_t         stat_o,
  input  logic [1:0]         base_i,
  input  logic               first_i,
  input  logic [LEN_W-1:0]   contig_len_i,
  input  logic [PRIOR_W-1:0] prior_multi_i,
  input  logic [KMER_W-1:0]  kmer_size_i,
  input  logic [STEP_W-1:0]  step_size_i,
  output logic               m_valid_o,
  output logic [WORD_W-1:0]  m_word_o,
  output logic               m_last_o,
  input  logic               m_ready_i
);

  logic [E_W-1:0]        e;
  logic [E_W+1:0]        ws;
  logic [E_W-4:0]        nw_full;
  logic                  fits;
  logic                  long_d;
  logic [LEN_W-1:0]      seen_d;
  logic [D_W-1:0]        d;

  logic [WIN_W-1:0]      win_q;
  logic [LEN_W-1:0]      seen_q;
  logic                  long_q;
  logic [MULTI_BITS-1:0] multi_q;

  logic [LEN_W-1:0]      len_q;
  logic [PRIOR_W-1:0]    prior_q;
  logic [LEN_W-1:0]      nn_q;
  logic [LEN_W:0]        nk_q;
  logic [PK_W-1:0]       pk_q;
  logic [DE_W-1:0]       de_q;
  logic [D_W-1:0]        im_q;
  logic [DEN_W-1:0]      den_q;
  logic [LEN_W:0]        ni_q;
  logic [S1_W-1:0]       s1_q;
  logic [S_W-1:0]        s2_q;
  logic [S_W-1:0]        s_q;
  logic [63:0]           plo_q;
  logic [PHI_W-1:0]      phi_q;
  logic [N_W-1:0]        n_q;
  logic [DVD_W-1:0]      dvd_q;
  logic [DEN2_W-1:0]     rem_q;
  logic [MULTI_BITS-1:0] q_q;
  logic                  sat_q;

  logic [DEN2_W-1:0]     den2;
  logic [DEN2_W:0]       rem_sh;
  logic [DEN2_W:0]       diff;
  logic                  ge;

  logic [2*PAD_BASES-1:0] win_pad;
  logic [WORD_W-1:0]      words [MAX_WORDS];
  logic [WORD_W-1:0]      m_word_d;
  logic                   m_valid_q;
  logic [WORD_W-1:0]      m_word_q;
  logic                   m_last_q;

  assign e       = E_W'(kmer_size_i) + E_W'(step_size_i) + E_W'(1);
  assign ws      = {1'b0, e, 1'b0} + (E_W+2)'(MULTI_BITS + WORD_W - 1);
  assign nw_full = ws[E_W+1:5];
  assign fits    = (e <= E_W'(MAX_EDGE_BASES)) && (nw_full <= (E_W-3)'(MAX_WORDS));
  assign long_d  = fits && (contig_len_i >= LEN_W'(e));
  assign seen_d  = first_i ? LEN_W'(1) : ((&seen_q) ? seen_q : seen_q + LEN_W'(1));
  assign d       = D_W'(step_size_i) + D_W'(2);

  assign stat_o.start_conv = first_i && long_d;
  assign stat_o.do_emit    = (first_i ? long_d : long_q) && fits && (seen_d >= LEN_W'(e));
  assign stat_o.nw         = nw_full[NW_W-1:0];
  assign stat_o.out_free   = !m_valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      seen_q  <= '0;
      long_q  <= 1'b0;
      multi_q <= '0;
    end else begin
      if (cmd_i.take) begin
        win_q  <= {win_q[WIN_W-3:0], base_i};
        seen_q <= seen_d;
        if (first_i) begin
          long_q <= long_d;
          if (!long_d) begin
            multi_q <= '0;
          end
        end
      end
      if (cmd_i.fin) begin
        multi_q <= sat_q ? '1 : q_q;
      end
    end
  end

  // divider: restoring, one quotient bit per cycle, saturating quotient
  assign den2   = {den_q, 9'b0};
  assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, den2};
  assign ge     = (rem_sh >= {1'b0, den2});

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && first_i) begin
      len_q   <= contig_len_i;
      prior_q <= prior_multi_i;
    end
    if (cmd_i.conv) begin
      unique case (cmd_i.conv_step)
        CS_LEN: begin
          nn_q <= len_q - LEN_W'(e) + LEN_W'(1);
          nk_q <= {1'b0, len_q} - (LEN_W+1)'(kmer_size_i) + (LEN_W+1)'(1);
          pk_q <= PK_W'(prior_q) * PK_W'(kmer_size_i);
          de_q <= DE_W'(d) * DE_W'(e[EB_W-1:0]);
        end
        CS_RANGE: begin
          im_q  <= (LEN_W'(d) < nn_q) ? d : nn_q[D_W-1:0];
          den_q <= DEN_W'(de_q) * DEN_W'(nn_q);
        end
        CS_SPAN: begin
          ni_q <= nk_q - (LEN_W+1)'({im_q, 1'b0}) + (LEN_W+1)'(2);
        end
        CS_PART: begin
          s1_q <= S1_W'(im_q - D_W'(1)) * S1_W'(im_q);
          s2_q <= S_W'(im_q) * S_W'(ni_q);
        end
        CS_SUM: begin
          s_q <= s2_q + S_W'(s1_q);
        end
        CS_MUL: begin
          plo_q <= 64'(pk_q) * 64'(s_q[31:0]);
          phi_q <= PHI_W'(pk_q) * PHI_W'(s_q[S_W-1:32]);
        end
        CS_ACC: begin
          n_q <= N_W'(plo_q) + {phi_q, 32'b0};
        end
        CS_DVD: begin
          dvd_q <= {1'b0, n_q, 1'b0} + DVD_W'({den_q, 8'b0});
          rem_q <= '0;
          q_q   <= '0;
          sat_q <= 1'b0;
        end
        default: ;
      endcase
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? diff[DEN2_W-1:0] : rem_sh[DEN2_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      q_q   <= {q_q[MULTI_BITS-2:0], ge};
      sat_q <= sat_q | q_q[MULTI_BITS-1];
    end
  end

  // edge words: newest base in the top bits of word 0
  always_comb begin
    int idx;
    win_pad = '0;
    win_pad[WIN_W-1:0] = win_q;
    for (int w = 0; w < MAX_WORDS; w++) begin
      words[w] = '0;
      for (int s = 0; s < BASES_PER_WORD; s++) begin
        idx = w * BASES_PER_WORD + s;
        if (E_W'(idx) < e) begin
          words[w][WORD_W-1-2*s -: 2] = win_pad[2*idx +: 2];
        end
      end
    end
    m_word_d = words[cmd_i.word_idx] | (cmd_i.word_last ? WORD_W'(multi_q) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_word_q <= m_word_d;
      m_last_q <= cmd_i.word_last;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_word_o  = m_word_q;
  assign m_last_o  = m_last_q;

endmodule

>>> sv/sliding_kmer_edge_packer.sv
// Sliding k-mer edge packer, top level. Instantiates skep_regs, skep_ctrl, skep_dp.
// A base that yields edges is sent as nw edge words, nw = (2E+47)/32 (3 at reset defaults).
// After the beat is taken the emit state loads each word into the output register;
// output stalls stretch the word phase. A contig start that yields edges first runs 8
// conversion steps, 72 divider steps (one quotient bit each) and one finish step.
// Reset is asynchronous: window and counters clear, k=21, step=10; no clearing pass.
module sliding_kmer_edge_packer import skep_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [63:0]           s_axis_tdata,  // base[1:0], contig_len[33:2], prior_multi[57:34]
  input  logic                  s_axis_tuser,  // first
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [WORD_W-1:0]     m_axis_tdata,  // word[31:0]
  output logic                  m_axis_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  skep_cmd_t         cmd;
  skep_stat_t        stat;
  logic [KMER_W-1:0] kmer_size;
  logic [STEP_W-1:0] step_size;

  skep_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .kmer_size_o (kmer_size),
    .step_size_o (step_size)
  );

  skep_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  skep_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .base_i        (s_axis_tdata[1:0]),
    .first_i       (s_axis_tuser),
    .contig_len_i  (s_axis_tdata[33:2]),
    .prior_multi_i (s_axis_tdata[57:34]),
    .kmer_size_i   (kmer_size),
    .step_size_i   (step_size),
    .m_valid_o     (m_axis_tvalid),
    .m_word_o      (m_axis_tdata),
    .m_last_o      (m_axis_tlast),
    .m_ready_i     (m_axis_tready)
  );

`ifndef SYNTHESIS
  a_conv_blocks_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && stat.start_conv) |=> !s_axis_tready)
    else $error("intake open during multiplicity conversion");

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> stat.out_free)
    else $error("edge word loaded over an unaccepted beat");

  a_words_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("edge word produced while idle");
`endif

endmodule

>>> verif/skep_edge_checker.sv
// Edge-word checker for the sliding k-mer edge packer: tracks register writes and
// accepted bases, predicts packed edge words and compares them with the output stream.
// Depends on skep_pkg for widths, reset values and register indexes.
module skep_edge_checker
  import skep_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [63:0]           s_axis_tdata,  // base[1:0], contig_len[33:2], prior_multi[57:34]
  input  logic                  s_axis_tuser,  // first
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [WORD_W-1:0]     m_axis_tdata,  // word[31:0]
  input  logic                  m_axis_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    words_pending,
  output int                    words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [127:0] MULTI_MAX = (128'd1 << MULTI_BITS) - 128'd1;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } edge_word_t;

  edge_word_t            expected_words_q [$];
  logic [KMER_W-1:0]     kmer_q = KMER_RESET;
  logic [STEP_W-1:0]     step_q = STEP_RESET;
  logic [1:0]            window_q [MAX_EDGE_BASES];
  logic [31:0]           seen_q = '0;
  logic [MULTI_BITS-1:0] multi_q = '0;
  logic                  long_q = 1'b0;

  initial begin
    fail_count    = 0;
    words_pending = 0;
    words_checked = 0;
    foreach (window_q[i]) window_q[i] = 2'd0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] edge stream mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // multiplicity at k scaled to (k+step+1)-mers, rounded half up, saturated
  function automatic logic [MULTI_BITS-1:0] edge_multiplicity(
    input logic [LEN_W-1:0]   len,
    input logic [PRIOR_W-1:0] prior,
    input logic [KMER_W-1:0]  k,
    input logic [E_W-1:0]     e
  );
    logic [63:0]  d, nk, nn, im, ne, ni, s, den;
    logic [127:0] num, quo;
    d   = 64'(e) - 64'(k) + 64'd1;
    nk  = 64'(len) - 64'(k) + 64'd1;
    nn  = 64'(len) - 64'(e) + 64'd1;
    im  = (d < nn) ? d : nn;
    ne  = im - 64'd1;
    ni  = nk - 64'd2 * ne;
    s   = ne * (ne + 64'd1) + im * ni;
    den = 64'd256 * d * 64'(e) * nn;
    num = 128'(64'(prior) * 64'(k)) * 128'(s);
    num = (num << 1) + 128'(den);
    quo = num / (128'(den) << 1);
    return (quo > MULTI_MAX) ? MULTI_MAX[MULTI_BITS-1:0] : quo[MULTI_BITS-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [E_W-1:0]    e;
    int                nw;
    logic              fits;
    logic [WORD_W-1:0] word;
    edge_word_t        want;
    if (!rst_ni) begin
      kmer_q  = KMER_RESET;
      step_q  = STEP_RESET;
      seen_q  = '0;
      multi_q = '0;
      long_q  = 1'b0;
      foreach (window_q[i]) window_q[i] = 2'd0;
      expected_words_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        words_checked++;
        if (expected_words_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h last %b", m_axis_tdata, m_axis_tlast));
        end else begin
          want = expected_words_q.pop_front();
          if (m_axis_tdata !== want.word)
            report_mismatch($sformatf("word %h, want %h", m_axis_tdata, want.word));
          if (m_axis_tlast !== want.last)
            report_mismatch($sformatf("last %b, want %b (word %h)", m_axis_tlast, want.last,
                                      want.word));
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        e    = E_W'(kmer_q) + E_W'(step_q) + E_W'(1);
        nw   = (2 * int'(e) + MULTI_BITS + 31) / 32;
        fits = (int'(e) <= MAX_EDGE_BASES) && (nw <= MAX_WORDS);
        if (s_axis_tuser) begin
          seen_q  = '0;
          long_q  = fits && (s_axis_tdata[33:2] >= 32'(e));
          multi_q = long_q ? edge_multiplicity(s_axis_tdata[33:2], s_axis_tdata[57:34],
                                               kmer_q, e) : '0;
        end
        for (int i = MAX_EDGE_BASES - 1; i > 0; i--) window_q[i] = window_q[i-1];
        window_q[0] = s_axis_tdata[1:0];
        if (seen_q != '1) seen_q++;

        if (long_q && fits && seen_q >= 32'(e)) begin
          for (int w = 0; w < nw; w++) begin
            word = '0;
            for (int b = 0; b < BASES_PER_WORD; b++) begin
              if (w * BASES_PER_WORD + b < int'(e))
                word[WORD_W-1-2*b -: 2] = window_q[w * BASES_PER_WORD + b];
            end
            if (w == nw - 1) word[MULTI_BITS-1:0] = word[MULTI_BITS-1:0] | multi_q;
            expected_words_q.push_back('{word: word, last: (w == nw - 1)});
          end
        end
      end

      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_KMER, 2'b00})
          kmer_q = pwdata[KMER_W-1:0];
        else if (paddr == {REG_STEP, 2'b00})
          step_q = pwdata[STEP_W-1:0];
      end
    end
    words_pending <= expected_words_q.size();
  end

endmodule

>>> verif/tb_sliding_kmer_edge_packer.sv
// Testbench top for sliding_kmer_edge_packer: clock, reset, base stream, APB register
// writes and output backpressure; verdict from skep_edge_checker's failure count.
// Depends on skep_pkg, sliding_kmer_edge_packer and skep_edge_checker.
module tb_sliding_kmer_edge_packer;
  import skep_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 120;  // conversion plus a full edge, with margin

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [63:0]           s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [WORD_W-1:0]     m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  int                    fail_count;
  int                    words_pending;
  int                    words_checked;

  bit                    gaps_on = 1'b1;
  int                    bases_sent = 0;
  int                    settings_used = 1;
  logic [KMER_W-1:0]     k_now = KMER_RESET;
  logic [STEP_W-1:0]     step_now = STEP_RESET;

  sliding_kmer_edge_packer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  skep_edge_checker u_edge_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .words_pending (words_pending),
    .words_checked (words_checked)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !gaps_on || ($urandom_range(99) >= 34);
  end

  task automatic push_base(input logic [1:0] b, input logic f, input logic [31:0] len,
                           input logic [23:0] prior);
    if (gaps_on) begin
      while ($urandom_range(99) < 34) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, prior, len, b};
    s_axis_tuser  <= f;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bases_sent++;
  endtask

  // stop sending and let every outstanding edge and conversion finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (words_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic retune(input logic [KMER_W-1:0] k, input logic [STEP_W-1:0] st);
    settle();
    reg_write({REG_KMER, 2'b00}, ($urandom & 32'hFFFF_FF00) | 32'(k));
    reg_write({REG_STEP, 2'b00}, ($urandom & 32'hFFFF_FFE0) | 32'(st));
    k_now    = k;
    step_now = st;
    settings_used++;
  endtask

  // mostly well-formed contigs; some noise beats, short and huge lengths
  task automatic feed_contigs(input int n_items);
    int          left, run, e_len, pick;
    logic [31:0] len;
    logic [23:0] prior;
    e_len = int'(k_now) + int'(step_now) + 1;
    run   = $urandom_range(3);
    // continuation of whatever contig was open under the previous sizes
    for (int i = 0; i < run; i++)
      push_base(2'($urandom_range(3)), 1'b0, $urandom, 24'($urandom));
    left = n_items - run;
    while (left > 0) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        push_base(2'($urandom_range(3)), 1'($urandom_range(1)), $urandom, 24'($urandom));
        left--;
      end else begin
        if (pick < 16)
          len = $urandom_range(e_len - 1, 0);
        else if (pick < 24)
          len = $urandom;
        else
          len = e_len + $urandom_range(10);
        case ($urandom_range(9))
          0:       prior = '0;
          1:       prior = '1;
          default: prior = 24'($urandom);
        endcase
        if (len < e_len)
          run = $urandom_range(4, 1);
        else if (len > e_len + 10)
          run = e_len + $urandom_range(10);
        else
          run = int'(len) + $urandom_range(2);
        if (run > left) run = left;
        push_base(2'($urandom_range(3)), 1'b1, len, prior);
        for (int i = 1; i < run; i++)
          push_base(2'($urandom_range(3)), 1'b0, $urandom, 24'($urandom));
        left -= run;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no contig start yet: window shifts only
    push_base(2'd3, 1'b0, '1, '1);
    push_base(2'd1, 1'b0, '0, '0);
    push_base(2'd2, 1'b0, 32'h5A5A_A5A5, 24'hA5_5A5A);
    // contig shorter than one edge at reset sizes
    push_base(2'd0, 1'b1, 32'd5, 24'h00_0100);
    push_base(2'd3, 1'b0, '0, '0);

    retune(8'd1, 5'd1);
    push_base(2'd1, 1'b1, 32'd3, 24'hFF_FFFF);
    push_base(2'd2, 1'b0, '0, '0);
    push_base(2'd3, 1'b0, '0, '0);
    push_base(2'd0, 1'b0, '0, '0);  // past contig_len, still emits
    push_base(2'd3, 1'b1, 32'd0, 24'd0);
    push_base(2'd1, 1'b0, '0, '0);
    push_base(2'd0, 1'b1, '1, 24'h00_0180);
    push_base(2'd1, 1'b0, '0, '0);
    push_base(2'd2, 1'b0, '0, '0);
    push_base(2'd3, 1'b0, '0, '0);

    // edge longer than the window: silent
    retune(8'd246, 5'd29);
    push_base(2'd1, 1'b1, 32'd300, 24'h00_8000);
    push_base(2'd2, 1'b0, '0, '0);
    push_base(2'd3, 1'b0, '0, '0);
    // sizes change mid-contig; latched state stays
    retune(8'd1, 5'd2);
    push_base(2'd0, 1'b0, '0, '0);
    push_base(2'd1, 1'b0, '0, '0);
    retune(8'd1, 5'd1);
    push_base(2'd2, 1'b1, 32'd100, 24'h01_0000);
    push_base(2'd3, 1'b0, '0, '0);
    push_base(2'd0, 1'b0, '0, '0);
    retune(8'd2, 5'd1);
    push_base(2'd1, 1'b0, '0, '0);
    push_base(2'd2, 1'b0, '0, '0);

    retune(KMER_RESET, STEP_RESET);
    feed_contigs(12);
    settle();
    feed_contigs(12);

    retune(8'd34, 5'd29);
    gaps_on <= 1'b0;
    feed_contigs(70);
    gaps_on <= 1'b1;

    retune(8'd1, 5'd1);
    feed_contigs(12);

    retune(8'($urandom_range(20, 1)), 5'($urandom_range(12, 1)));
    feed_contigs(20);

    retune(8'd35, 5'd29);
    feed_contigs(5);

    settle();
    $display("Run covered %0d bases under %0d k/step settings, %0d edge words compared.",
             bases_sent, settings_used, words_checked);
    if (fail_count == 0) begin
      $display("sliding_kmer_edge_packer verification clean");
    end else begin
      $display("sliding_kmer_edge_packer verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d edge words still outstanding.", words_pending);
    $display("sliding_kmer_edge_packer verification failed");
    $finish;
  end

endmodule
